[src/wtsp_pkg.sv]
package wtsp_pkg;

  localparam int ClipW  = 50;
  localparam int PixW   = 20;
  localparam int QW     = 22;
  localparam logic signed [ClipW-1:0] WMin = 50'sd6554;
  localparam logic signed [PixW-1:0] PixMax = 20'sd524287;
  localparam logic signed [PixW-1:0] PixMin = -20'sd524288;
  localparam int NumRegs = 8;
  localparam int AddrW = 6;

  typedef struct packed {
    logic signed [ClipW-1:0] cx;
    logic signed [ClipW-1:0] cy;
    logic signed [ClipW-1:0] cw;
  } clip_t;

endpackage

[src/wtsp_transform.sv]
module wtsp_transform (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic                    in_valid,
  input  logic signed [31:0]      px,
  input  logic signed [31:0]      py,
  input  logic signed [31:0]      pz,
  input  logic                    col,
  input  logic [511:0]            mat,
  output logic                    out_valid,
  output wtsp_pkg::clip_t         clip
);
  import wtsp_pkg::*;

  logic signed [31:0] m [16];
  logic signed [31:0] sel [3][4];
  logic signed [31:0] offs [3];
  logic signed [31:0] p [3];
  logic signed [47:0] prod [3][3];
  logic signed [31:0] off_q [3];
  logic v1, v2;
  logic signed [ClipW-1:0] sum [3];

  always_comb begin
    for (int k = 0; k < 16; k++) m[k] = mat[32*k +: 32];
    p[0] = px; p[1] = py; p[2] = pz;
    // Rows 0, 1 and 3 of the clip vector are used; depth is never needed.
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        sel[r][c] = col ? m[4*c + (r == 2 ? 3 : r)] : m[4*(r == 2 ? 3 : r) + c];
      end
      offs[r] = sel[r][3];
    end
  end

  // Stage one: nine products, floored to Q32.16.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
    if (advance) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= 48'((64'(p[c]) * 64'(sel[r][c])) >>> 16);
        end
        off_q[r] <= offs[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = ClipW'(prod[r][0]) + ClipW'(prod[r][1]) + ClipW'(prod[r][2])
             + ClipW'(off_q[r]);
    end
  end

  // Stage two: sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
    if (advance) begin
      clip.cx <= sum[0];
      clip.cy <= sum[1];
      clip.cw <= sum[2];
    end
  end

  assign out_valid = v2;

endmodule

[src/wtsp_divider.sv]
module wtsp_divider #(
  parameter int HALF = 640
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     in_valid,
  input  logic                     in_vis,
  input  logic signed [63:0]       num,
  input  logic [63:0]              den,
  output logic                     out_valid,
  output logic                     out_vis,
  output logic signed [wtsp_pkg::PixW-1:0] pix,
  input  logic                     invert
);
  import wtsp_pkg::*;

  localparam int Bits = QW;
  localparam int Per = 2;
  localparam int Stages = (Bits + Per - 1) / Per;

  // Restoring long division of 256*|num| by den; the quotient is clamped
  // to QW bits since anything larger saturates anyway.
  logic [63:0]     rem  [Stages+1];
  logic [Bits-1:0] quo  [Stages+1];
  logic            ng   [Stages+1];
  logic            vl   [Stages+1];
  logic            vs   [Stages+1];
  logic            ovf  [Stages+1];
  logic [63:0]     dn   [Stages+1];
  logic [71:0]     mag;
  logic [63:0]     rem_n [Stages];
  logic [Bits-1:0] quo_n [Stages];
  logic            ovf_n [Stages];

  assign mag = {(num < 0) ? 64'(-num) : 64'(num), 8'd0};

  always_comb begin
    rem[0] = 64'(mag >> Bits);
    ovf[0] = (mag >> Bits) >= {8'd0, den};
    quo[0] = mag[Bits-1:0];
    ng[0]  = num < 0;
    vl[0]  = in_valid;
    vs[0]  = in_vis;
    dn[0]  = den;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_st
    always_comb begin
      logic [64:0] t;
      rem_n[s] = rem[s];
      quo_n[s] = quo[s];
      ovf_n[s] = ovf[s];
      for (int b = 0; b < Per; b++) begin
        t = {rem_n[s], quo_n[s][Bits-1]};
        quo_n[s] = quo_n[s] << 1;
        if (t >= {1'b0, dn[s]}) begin
          rem_n[s] = 64'(t - {1'b0, dn[s]});
          quo_n[s][0] = 1'b1;
        end else begin
          rem_n[s] = t[63:0];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else if (advance) begin
        vl[s+1] <= vl[s];
      end
      if (advance) begin
        rem[s+1] <= rem_n[s];
        quo[s+1] <= quo_n[s];
        ovf[s+1] <= ovf_n[s];
        ng[s+1]  <= ng[s];
        vs[s+1]  <= vs[s];
        dn[s+1]  <= dn[s];
      end
    end
  end

  logic signed [Bits+1:0] q_s, base, r;

  always_comb begin
    q_s  = ovf[Stages] ? (Bits+2)'(1 << Bits) : (Bits+2)'({2'b0, quo[Stages]});
    if (ng[Stages] ^ invert) q_s = -q_s;
    base = (Bits+2)'(HALF * 256);
    r    = base + q_s;
    if (!vs[Stages])            pix = '0;
    else if (r > (Bits+2)'(PixMax)) pix = PixMax;
    else if (r < (Bits+2)'(PixMin)) pix = PixMin;
    else                        pix = PixW'(r);
  end

  assign out_valid = vl[Stages];
  assign out_vis   = vs[Stages];

endmodule

[src/world_to_screen_projection.sv]
// Channel  | handshake            | payload
// ---------+----------------------+--------------------------------------
// point in | in_valid / in_stall  | point_x, point_y, point_z, transposed
// pixel out| out_valid / out_stall| pixel_x, pixel_y, visible
// config   | APB write/read       | paddr, pwdata, prdata (64-bit regs)
//
// One item enters per cycle while in_stall is low. The stages: one product stage,
// one sum stage, one scaling stage and eleven stages of a two-bit-per-stage
// restoring divider. Reset clears all valid bits and the matrix. A stall at
// the output freezes the whole pipe; in_stall is high only while the last
// stage holds an item that the sink is not taking.
module world_to_screen_projection #(
  parameter int SCREEN_WIDTH  = 1280,
  parameter int SCREEN_HEIGHT = 720
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            point_x,
  input  logic signed [31:0]            point_y,
  input  logic signed [31:0]            point_z,
  input  logic                          transposed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [19:0]            pixel_x,
  output logic signed [19:0]            pixel_y,
  output logic                          visible,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wtsp_pkg::AddrW-1:0]    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  import wtsp_pkg::*;

  localparam int HW = SCREEN_WIDTH / 2;
  localparam int HH = SCREEN_HEIGHT / 2;

  logic [63:0] matrix_pair [NumRegs];
  logic [511:0] mat;
  logic advance;
  logic t_valid, s_valid, dx_valid, dy_valid, dx_vis, dy_vis;
  clip_t clip;
  logic signed [63:0] nx, ny;
  logic [63:0] den;
  logic vis;

  assign pready = 1'b1;
  // Eight registers fill the whole three-bit index, so every read hits one.
  assign prdata = matrix_pair[paddr[5:3]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) matrix_pair[i] <= '0;
    end else if (psel && penable && pwrite) begin
      matrix_pair[paddr[5:3]] <= pwdata;
    end
  end

  always_comb begin
    for (int i = 0; i < NumRegs; i++) mat[64*i +: 64] = matrix_pair[i];
  end

  // The pipe moves whenever its last stage is empty or being taken.
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  wtsp_transform u_xf (
    .clk, .rst, .advance, .in_valid,
    .px(point_x), .py(point_y), .pz(point_z), .col(transposed),
    .mat, .out_valid(t_valid), .clip
  );

  // Scaling stage: numerators h*c, visibility test.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (advance) begin
      s_valid <= t_valid;
    end
    if (advance) begin
      nx  <= 64'(clip.cx) * 64'(HW);
      ny  <= 64'(clip.cy) * 64'(HH);
      vis <= clip.cw >= WMin;
      den <= (clip.cw >= WMin) ? 64'(clip.cw) : 64'd1;
    end
  end

  wtsp_divider #(.HALF(HW)) u_dx (
    .clk, .rst, .advance, .in_valid(s_valid), .in_vis(vis), .num(nx), .den,
    .out_valid(dx_valid), .out_vis(dx_vis), .pix(pixel_x), .invert(1'b0)
  );

  wtsp_divider #(.HALF(HH)) u_dy (
    .clk, .rst, .advance, .in_valid(s_valid), .in_vis(vis), .num(ny), .den,
    .out_valid(dy_valid), .out_vis(dy_vis), .pix(pixel_y), .invert(1'b1)
  );

  assign out_valid = dx_valid;
  assign visible   = dx_vis;

`ifndef SYNTHESIS
  a_lanes_valid: assert property (@(posedge clk) disable iff (rst)
    dx_valid == dy_valid)
    else $error("divider lanes out of step");
  a_lanes_vis: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> dx_vis == dy_vis)
    else $error("visibility differs between lanes");
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !visible) |-> (pixel_x == '0 && pixel_y == '0))
    else $error("hidden point with nonzero pixels");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(pixel_x))
    else $error("stalled result changed");
`endif

endmodule

[dv/world_to_screen_projection_checker.sv]
module world_to_screen_projection_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               transposed,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [19:0] pixel_x,
  input  logic signed [19:0] pixel_y,
  input  logic               visible,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending_pixels,
  output int                 visible_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic               vis;
  } pixel_t;

  localparam longint HalfW = 640;
  localparam longint HalfH = 360;

  logic [63:0] matrix_regs [8];
  pixel_t expected_pixels [$];

  function automatic longint coef(int k);
    logic [63:0] p;
    p = matrix_regs[k >> 1];
    return (k & 1) ? longint'($signed(p[63:32])) : longint'($signed(p[31:0]));
  endfunction

  function automatic longint mul_q16(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint div_scaled(longint num, longint den);
    longint m, q;
    m = (num < 0) ? -num : num;
    q = (m / den) * 256 + ((m % den) * 256) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp_pixel(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  function automatic pixel_t project_point(longint x, longint y, longint z, logic col);
    longint clip [4];
    pixel_t r;
    for (int i = 0; i < 4; i++) begin
      if (col) begin
        clip[i] = mul_q16(x, coef(i)) + mul_q16(y, coef(4 + i)) +
                  mul_q16(z, coef(8 + i)) + coef(12 + i);
      end else begin
        clip[i] = mul_q16(x, coef(4*i)) + mul_q16(y, coef(4*i + 1)) +
                  mul_q16(z, coef(4*i + 2)) + coef(4*i + 3);
      end
    end
    if (clip[3] < 6554) begin
      r = '0;
    end else begin
      r.px = 20'(clamp_pixel(HalfW * 256 + div_scaled(HalfW * clip[0], clip[3])));
      r.py = 20'(clamp_pixel(HalfH * 256 - div_scaled(HalfH * clip[1], clip[3])));
      r.vis = 1'b1;
    end
    return r;
  endfunction

  assign pending_pixels = expected_pixels.size();

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      for (int i = 0; i < 8; i++) matrix_regs[i] <= '0;
      fail_count <= 0;
      visible_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[5:3] < 8)
        matrix_regs[paddr[5:3]] <= pwdata;
      if (in_valid && !in_stall)
        expected_pixels.push_back(project_point(point_x, point_y, point_z, transposed));
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          if (fail_count < 10) $display("unexpected pixel item %0d %0d %0b",
                                        pixel_x, pixel_y, visible);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (want.vis) visible_count <= visible_count + 1;
          if (want.px !== pixel_x || want.py !== pixel_y || want.vis !== visible) begin
            if (fail_count < 10)
              $display("pixel mismatch: expected x=%0d y=%0d vis=%0b, got x=%0d y=%0d vis=%0b",
                       want.px, want.py, want.vis, pixel_x, pixel_y, visible);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[dv/world_to_screen_projection_test.sv]
module world_to_screen_projection_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
  logic transposed = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [19:0] pixel_x, pixel_y;
  logic visible;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  int fail_count, pending_pixels, visible_count;
  int points_sent = 0;
  int settings_done = 0;

  // The pipe is fourteen stages deep, so a short drain pause covers it.
  localparam int Drain = 40;
  localparam logic [31:0] One = 32'h0001_0000;

  always #1 clk = ~clk;

  world_to_screen_projection uut (.*);

  world_to_screen_projection_checker checker_i (.*);

  // Gaps are mostly short; once in a while a long one is taken.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The sink stalls at random, with phases in which it never stalls.
  logic sink_calm = 1'b0;
  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) sink_calm <= ~sink_calm;
      out_stall <= sink_calm ? 1'b0 : ($urandom_range(0, 99) < 25);
    end
  end

  task automatic write_pair(int idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 6'(idx * 8); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Pushes one point and holds it until the block accepts it. With no gap
  // the next point follows in the very next cycle.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic t);
    int g;
    g = gap_length();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x; point_y <= y; point_z <= z; transposed <= t;
    do @(posedge clk); while (in_stall);
    points_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  // A coefficient drawn so that projections stay mostly in a sensible range,
  // with occasional full-width values.
  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
  endfunction

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
    return 32'($signed($urandom_range(0, 200 * 65536)) - 100 * 65536);
  endfunction

  // Loads a matrix whose w row (or column) is biased positive so that most
  // points end up visible.
  task automatic load_random_matrix(bit w_positive);
    logic [31:0] m [16];
    for (int i = 0; i < 16; i++) m[i] = rand_coef();
    if (w_positive) begin
      m[15] = 32'($urandom_range(2, 40) * 65536);
      m[14] = 32'($urandom_range(0, 2 * 65536));
      m[11] = 32'($urandom_range(0, 2 * 65536));
    end
    for (int k = 0; k < 8; k++) write_pair(k, {m[2*k+1], m[2*k]});
    settings_done++;
  endtask

  task automatic random_points(int n);
    repeat (n) send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 1));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Null matrix after reset: nothing is visible.
    send_point(One, One, One, 1'b0);
    wait_idle();

    // Identity with w = 1: both orders, origin and the screen edges.
    for (int k = 0; k < 8; k++) write_pair(k, 64'h0);
    write_pair(0, {32'h0, One});
    write_pair(2, {One, 32'h0});
    write_pair(5, {32'h0, One});
    write_pair(7, {One, 32'h0});
    settings_done++;
    send_point(0, 0, 0, 1'b0);
    send_point(One, One, 0, 1'b0);
    send_point(-One, -One, 0, 1'b1);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    send_point(32'hffff_ffff, 32'h0000_0001, 32'h5555_5555, 1'b0);
    wait_idle();

    // w taken from z: points on both sides of the 0.1 threshold, and w < 0.
    for (int k = 0; k < 8; k++) write_pair(k, 64'h0);
    write_pair(0, {32'h0, One});
    write_pair(2, {32'h0, 32'h0});
    write_pair(2, {32'h0, One});
    write_pair(7, {32'h0, One});
    settings_done++;
    send_point(One, One, 32'd6554, 1'b0);
    send_point(One, One, 32'd6553, 1'b0);
    send_point(One, -One, -One, 1'b0);
    send_point(32'h0100_0000, 32'h0100_0000, 32'd6554, 1'b0);
    send_point(32'hff00_0000, 32'hff00_0000, 32'd6554, 1'b0);
    send_point(One, One, 32'd6554, 1'b1);
    wait_idle();

    // Extreme register contents.
    for (int k = 0; k < 8; k++) write_pair(k, 64'hffff_ffff_ffff_ffff);
    settings_done++;
    send_point(One, One, One, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    wait_idle();
    for (int k = 0; k < 8; k++) write_pair(k, 64'h7fff_ffff_7fff_ffff);
    settings_done++;
    send_point(One, 0, 0, 1'b0);
    send_point(32'h8000_0000, One, 32'h7fff_ffff, 1'b1);
    wait_idle();

    // Random phases, each with its own matrix.
    for (int ph = 0; ph < 8; ph++) begin
      load_random_matrix(ph != 3);
      random_points(110);
      wait_idle();
    end

    $display("Sent %0d points over %0d matrix settings; %0d came out visible.",
             points_sent, settings_done, visible_count);
    if (fail_count == 0) begin
      $display("world_to_screen_projection test passed");
    end else begin
      $display("world_to_screen_projection test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("world_to_screen_projection test failed");
    $finish;
  end
endmodule
